// ===== src/rectangle_raster_canvas_unit_assert.svh =====
// assertion macros for the canvas rasterizer, sampled on clk, quiet in reset
`ifndef RECTANGLE_RASTER_CANVAS_UNIT_ASSERT_SVH
`define RECTANGLE_RASTER_CANVAS_UNIT_ASSERT_SVH

// property that must hold at every edge
`define RRC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("canvas check failed");

// consequent must hold after the antecedent, as a non-overlapping implication
`define RRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("canvas sequence check failed");

`endif

// ===== src/rrc_pkg.sv =====
`default_nettype none

package rrc_pkg;

    localparam int MAX_SIDE_DEF      = 512;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int COORD_W = 24;
    localparam int SYM_W   = 8;
    localparam int CFG_W   = 10;
    localparam int POS_W   = 9;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_DRAW  = 2'd0;
    localparam kind_t KIND_READ  = 2'd1;
    localparam kind_t KIND_CLEAR = 2'd2;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_CANVAS_WIDTH      = 2'd0;
    localparam cfg_index_t CFG_CANVAS_HEIGHT     = 2'd1;
    localparam cfg_index_t CFG_BACKGROUND_SYMBOL = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET      = 10'd1;
    localparam logic [CFG_W-1:0] HEIGHT_RESET     = 10'd1;
    localparam logic [SYM_W-1:0] BACKGROUND_RESET = 8'd32;

    typedef struct packed {
        kind_t                     kind;
        logic                      filled;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic signed [COORD_W-1:0] rect_width;
        logic signed [COORD_W-1:0] rect_height;
        logic [SYM_W-1:0]          draw_symbol;
        logic [POS_W-1:0]          read_row;
        logic [POS_W-1:0]          read_column;
    } item_t;

    typedef struct packed {
        logic             status;
        logic [SYM_W-1:0] pixel_value;
    } result_t;

    // coverage of one pixel coordinate against one axis of the rectangle
    typedef struct packed {
        logic covered;
        logic near;
    } span_t;

endpackage

`default_nettype wire

// ===== src/rrc_ram.sv =====
`default_nettype none

module rrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/rrc_edge_unit.sv =====
`default_nettype none

module rrc_edge_unit #(
    parameter int DATA_W        = 27,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic signed [DATA_W-1:0] pos,
    input  wire logic signed [DATA_W-1:0] lo,
    input  wire logic signed [DATA_W-1:0] hi,
    output rrc_pkg::span_t                span
);
    import rrc_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRACTION_BITS;

    logic signed [DATA_W-1:0] d_lo;
    logic signed [DATA_W-1:0] d_hi;

    // distance to the low and the high edge of the closed interval
    assign d_lo = pos - lo;
    assign d_hi = hi - pos;

    assign span.covered = !d_lo[DATA_W-1] && !d_hi[DATA_W-1];
    assign span.near    = (d_lo < ONE) || (d_hi < ONE);

endmodule

`default_nettype wire

// ===== src/rectangle_raster_canvas_unit.sv =====
// channel  | handshake             | payload          | notes
// ---------+-----------------------+------------------+------------------------------
// item     | item_valid/item_stall | rrc_pkg::item_t  | draw, read, clear
// result   | result_valid/stall    | rrc_pkg::result_t| one per item, registered
// cfg      | cfg_valid/cfg_ready   | cfg_index,data   | always ready, write when idle
//
// draw and clear walk the canvas in use row by row: a setup step (S_ROW) per row,
// then a step (S_COL) per pixel; a read passes through S_READ, anything else goes
// straight to S_DONE. the walk is serial because of the single write port of the
// canvas memory and the one shared edge compare unit that serves both row and column test.
// rst_n is asynchronous; it clears control, config and the corrupt flag but not the
// canvas, which holds garbage until the first clear.
// item_stall is high while an item is in work; a held result only blocks the finish.
`default_nettype none

module rectangle_raster_canvas_unit #(
    parameter int MAX_SIDE      = rrc_pkg::MAX_SIDE_DEF,
    parameter int FRACTION_BITS = rrc_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire rrc_pkg::item_t            item,

    output logic                           result_valid,
    input  wire logic                      result_stall,
    output rrc_pkg::result_t               result,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire rrc_pkg::cfg_index_t       cfg_index,
    input  wire logic [rrc_pkg::CFG_W-1:0] cfg_data
);
    import rrc_pkg::*;

    // index bits of one side, bits of a count that can reach the side length
    localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SZ_W   = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    // signed datapath wide enough for pixel positions and the far edges
    localparam int DATA_W = ((SZ_W + FRACTION_BITS > COORD_W + 1) ?
                             SZ_W + FRACTION_BITS : COORD_W + 1) + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_COL,
        S_READ,
        S_DONE
    } state_t;

    // configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [SYM_W-1:0] background_reg;

    // sequencer and item context
    state_t                   state_reg,    state_next;
    logic                     corrupt_reg,  corrupt_next;
    logic [SZ_W-1:0]          row_reg,      row_next;
    logic [SZ_W-1:0]          col_reg,      col_next;
    span_t                    row_span_reg, row_span_next;
    logic                     clear_reg,    clear_next;
    logic                     fill_reg,     fill_next;
    logic                     is_read_reg,  is_read_next;
    logic                     hit_reg,      hit_next;
    logic [SYM_W-1:0]         sym_reg,      sym_next;
    logic [IDX_W-1:0]         rd_row_reg,   rd_row_next;
    logic [IDX_W-1:0]         rd_col_reg,   rd_col_next;
    logic signed [DATA_W-1:0] x_reg,        x_next;
    logic signed [DATA_W-1:0] x_end_reg,    x_end_next;
    logic signed [DATA_W-1:0] y_reg,        y_next;
    logic signed [DATA_W-1:0] y_end_reg,    y_end_next;
    logic                     result_valid_reg, result_valid_next;
    result_t                  result_reg,   result_next;

    logic [SZ_W-1:0]          w_used;
    logic [SZ_W-1:0]          h_used;
    logic                     accept;
    logic                     bad_dims;
    logic                     empty;
    logic signed [DATA_W-1:0] unit_pos;
    logic signed [DATA_W-1:0] unit_lo;
    logic signed [DATA_W-1:0] unit_hi;
    span_t                    unit_span;
    logic                     paint;
    logic                     ram_we;
    logic                     ram_re;
    logic [SYM_W-1:0]         ram_rdata;
    logic                     out_free;

    // sides in use, saturated to the canvas memory
    assign w_used = (32'(width_reg) > MAX_SIDE)  ? SZ_W'(MAX_SIDE) : SZ_W'(width_reg);
    assign h_used = (32'(height_reg) > MAX_SIDE) ? SZ_W'(MAX_SIDE) : SZ_W'(height_reg);
    assign empty  = (w_used == '0) || (h_used == '0);

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // a non-positive width or height poisons the stream
    assign bad_dims = item.rect_width[COORD_W-1]  || (item.rect_width == '0) ||
                      item.rect_height[COORD_W-1] || (item.rect_height == '0);

    // the one compare unit: row test in the row setup cycle, column test otherwise
    always_comb
    begin
        if (state_reg == S_ROW)
        begin
            unit_pos = DATA_W'(row_reg) << FRACTION_BITS;
            unit_lo  = y_reg;
            unit_hi  = y_end_reg;
        end
        else
        begin
            unit_pos = DATA_W'(col_reg) << FRACTION_BITS;
            unit_lo  = x_reg;
            unit_hi  = x_end_reg;
        end
    end

    rrc_edge_unit #(
        .DATA_W        (DATA_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_edge (
        .pos  (unit_pos),
        .lo   (unit_lo),
        .hi   (unit_hi),
        .span (unit_span)
    );

    // clear paints everything; outline needs a pixel within one unit of an edge
    assign paint = clear_reg ||
                   (row_span_reg.covered && unit_span.covered &&
                    (fill_reg || row_span_reg.near || unit_span.near));

    assign ram_we = (state_reg == S_COL) && paint;
    assign ram_re = (state_reg == S_READ);

    rrc_ram #(
        .WIDTH (SYM_W),
        .DEPTH (DEPTH)
    ) u_canvas (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({IDX_W'(row_reg), IDX_W'(col_reg)}),
        .wdata (sym_reg),
        .re    (ram_re),
        .raddr ({rd_row_reg, rd_col_reg}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        corrupt_next      = corrupt_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        row_span_next     = row_span_reg;
        clear_next        = clear_reg;
        fill_next         = fill_reg;
        is_read_next      = is_read_reg;
        hit_next          = hit_reg;
        sym_next          = sym_reg;
        rd_row_next       = rd_row_reg;
        rd_col_next       = rd_col_reg;
        x_next            = x_reg;
        x_end_next        = x_end_reg;
        y_next            = y_reg;
        y_end_next        = y_end_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_next     = '0;
                    col_next     = '0;
                    clear_next   = (item.kind == KIND_CLEAR);
                    fill_next    = item.filled;
                    is_read_next = (item.kind == KIND_READ);
                    hit_next     = (32'(item.read_row) < 32'(h_used)) &&
                                   (32'(item.read_column) < 32'(w_used));
                    sym_next     = (item.kind == KIND_CLEAR) ? background_reg
                                                             : item.draw_symbol;
                    rd_row_next  = IDX_W'(item.read_row);
                    rd_col_next  = IDX_W'(item.read_column);
                    x_next       = DATA_W'(item.rect_x);
                    y_next       = DATA_W'(item.rect_y);
                    x_end_next   = DATA_W'(item.rect_x) + DATA_W'(item.rect_width);
                    y_end_next   = DATA_W'(item.rect_y) + DATA_W'(item.rect_height);
                    state_next   = S_DONE;
                    priority if (item.kind == KIND_CLEAR)
                    begin
                        corrupt_next = 1'b0;
                        if (!empty)
                        begin
                            state_next = S_ROW;
                        end
                    end
                    else if (item.kind == KIND_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (item.kind == KIND_DRAW && !corrupt_reg)
                    begin
                        if (bad_dims)
                        begin
                            corrupt_next = 1'b1;
                        end
                        else if (!empty)
                        begin
                            state_next = S_ROW;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ROW:
            begin
                row_span_next = unit_span;
                col_next      = '0;
                state_next    = S_COL;
            end
            S_COL:
            begin
                if (col_reg == SZ_W'(w_used - 1'b1))
                begin
                    if (row_reg == SZ_W'(h_used - 1'b1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next       = 1'b1;
                    result_next.status      = corrupt_reg;
                    result_next.pixel_value = (is_read_reg && hit_reg) ? ram_rdata : '0;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            corrupt_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            width_reg        <= WIDTH_RESET;
            height_reg       <= HEIGHT_RESET;
            background_reg   <= BACKGROUND_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            corrupt_reg      <= corrupt_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CANVAS_WIDTH:      width_reg      <= cfg_data;
                    CFG_CANVAS_HEIGHT:     height_reg     <= cfg_data;
                    CFG_BACKGROUND_SYMBOL: background_reg <= cfg_data[SYM_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // item context
    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        col_reg      <= col_next;
        row_span_reg <= row_span_next;
        clear_reg    <= clear_next;
        fill_reg     <= fill_next;
        is_read_reg  <= is_read_next;
        hit_reg      <= hit_next;
        sym_reg      <= sym_next;
        rd_row_reg   <= rd_row_next;
        rd_col_reg   <= rd_col_next;
        x_reg        <= x_next;
        x_end_reg    <= x_end_next;
        y_reg        <= y_next;
        y_end_reg    <= y_end_next;
    end

`include "rectangle_raster_canvas_unit_assert.svh"

    // every accepted item leaves idle
    `RRC_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE)
    // the walk stays inside the canvas in use
    `RRC_ASSERT_ALWAYS(a_walk_bounds, state_reg != S_COL || (row_reg < h_used && col_reg < w_used))
    // the corrupt flag only rises after a draw transfer
    `RRC_ASSERT_ALWAYS(a_corrupt_cause, !$rose(corrupt_reg) || $past(accept && item.kind == KIND_DRAW))
    // canvas writes happen only during a draw or clear walk
    `RRC_ASSERT_ALWAYS(a_write_walk, !ram_we || (!is_read_reg && state_reg == S_COL))

endmodule

`default_nettype wire
